// File: rtl/cobsrx_pkg.sv
// shared types, status codes and crc helper for the cobs frame receiver
// no dependencies
package cobsrx_pkg;

   localparam int MaxRawBytesDefault = 256;
   localparam int CmdDepthDefault    = 4;
   localparam int OutDepth           = 2;

   localparam logic [7:0]  Delimiter = 8'h00;
   localparam logic [7:0]  CodeMax   = 8'hFF;
   localparam logic [15:0] CrcInit   = 16'hFFFF;
   localparam logic [15:0] CrcPoly   = 16'hA001;

   typedef enum logic [2:0] {
      STATUS_OK    = 3'd0,
      STATUS_CRC   = 3'd1,
      STATUS_TRUNC = 3'd2,
      STATUS_LEN   = 3'd3,
      STATUS_OVF   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      RX_HUNT  = 2'b01,
      RX_FRAME = 2'b10
   } rx_state_type;

   // command from the cobs front to the checking back end
   typedef struct packed {
      logic       is_close;
      logic [7:0] data;
      status_type pre_status;
   } cmd_type;

   typedef struct packed {
      logic       item_kind;
      logic [7:0] data_byte;
      logic [7:0] byte_position;
      status_type frame_status;
      logic [7:0] frame_length;
      logic       last;
   } item_type;

   function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: rtl/cobsrx_front.sv
// cobs front: byte classification, block counters, overflow and pre-status
// depends on cobsrx_pkg
module cobsrx_front #(
   parameter int MAX_RAW_BYTES = cobsrx_pkg::MaxRawBytesDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [7:0]          rx_byte,
   output logic                cmd_valid,
   output cobsrx_pkg::cmd_type cmd
);

   logic [7:0] block_remaining_ff, block_remaining_in;
   logic [7:0] previous_code_ff, previous_code_in;
   logic [8:0] raw_count_ff, raw_count_in;
   logic       overflow_ff, overflow_in;

   always_comb begin
      block_remaining_in = block_remaining_ff;
      previous_code_in   = previous_code_ff;
      raw_count_in       = raw_count_ff;
      overflow_in        = overflow_ff;
      cmd_valid          = 1'b0;
      cmd.is_close       = 1'b0;
      cmd.data           = rx_byte;
      cmd.pre_status     = cobsrx_pkg::STATUS_OK;
      if (in_valid) begin
         if (rx_byte == cobsrx_pkg::Delimiter) begin
            cmd_valid    = 1'b1;
            cmd.is_close = 1'b1;
            if (overflow_ff) begin
               cmd.pre_status = cobsrx_pkg::STATUS_OVF;
            end else if (raw_count_ff == 9'd0) begin
               cmd.pre_status = cobsrx_pkg::STATUS_LEN;
            end else if (block_remaining_ff != 8'd0) begin
               cmd.pre_status = cobsrx_pkg::STATUS_TRUNC;
            end
            block_remaining_in = 8'd0;
            previous_code_in   = 8'd0;
            raw_count_in       = 9'd0;
            overflow_in        = 1'b0;
         end else if (!overflow_ff) begin
            if (32'(raw_count_ff) >= MAX_RAW_BYTES) begin
               overflow_in = 1'b1;
            end else begin
               if (raw_count_ff != 9'h1FF) begin
                  raw_count_in = raw_count_ff + 9'd1;
               end
               if (block_remaining_ff == 8'd0) begin
                  // code byte: zero goes in at a block boundary
                  previous_code_in   = rx_byte;
                  block_remaining_in = rx_byte - 8'd1;
                  if (raw_count_ff != 9'd0 && previous_code_ff != cobsrx_pkg::CodeMax) begin
                     cmd_valid = 1'b1;
                     cmd.data  = 8'h00;
                  end
               end else begin
                  block_remaining_in = block_remaining_ff - 8'd1;
                  cmd_valid          = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_remaining_ff <= 8'd0;
         previous_code_ff   <= 8'd0;
         raw_count_ff       <= 9'd0;
         overflow_ff        <= 1'b0;
      end else begin
         block_remaining_ff <= block_remaining_in;
         previous_code_ff   <= previous_code_in;
         raw_count_ff       <= raw_count_in;
         overflow_ff        <= overflow_in;
      end
   end

endmodule

// File: rtl/cobsrx_queue.sv
// command queue between the cobs front and the checking back end
// depends on cobsrx_pkg
module cobsrx_queue #(
   parameter int DEPTH = cobsrx_pkg::CmdDepthDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cobsrx_pkg::cmd_type push_cmd,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output cobsrx_pkg::cmd_type head_cmd
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   cobsrx_pkg::cmd_type slot_ff [DEPTH];
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == CntW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/cobsrx_back.sv
// back end: frame length, crc check, status and result queue
// depends on cobsrx_pkg
module cobsrx_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  cobsrx_pkg::cmd_type cmd,
   output logic                cmd_pop,
   input  logic                out_pop,
   output logic                out_empty,
   output cobsrx_pkg::item_type out_item
);

   localparam int OutPtrW = (cobsrx_pkg::OutDepth > 1) ? $clog2(cobsrx_pkg::OutDepth) : 1;
   localparam int OutCntW = $clog2(cobsrx_pkg::OutDepth + 1);

   cobsrx_pkg::rx_state_type state_ff, state_in;
   logic [8:0]  decoded_count_ff, decoded_count_in;
   logic [7:0]  declared_ff, declared_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] rx_crc_ff, rx_crc_in;

   cobsrx_pkg::item_type slot_ff [cobsrx_pkg::OutDepth];
   logic [OutPtrW-1:0] head_ff, head_in;
   logic [OutCntW-1:0] count_ff, count_in;
   logic [OutPtrW-1:0] tail;

   cobsrx_pkg::item_type new_item;
   logic                 item_push;
   logic                 room;
   logic                 do_out_pop;

   assign room       = (count_ff != OutCntW'(cobsrx_pkg::OutDepth));
   assign cmd_pop    = cmd_valid && room;
   assign out_empty  = (count_ff == '0);
   assign out_item   = slot_ff[head_ff];
   assign do_out_pop = out_pop && !out_empty;
   assign tail       = head_ff + OutPtrW'(count_ff);

   always_comb begin
      cobsrx_pkg::status_type st;
      logic [7:0] decl;
      logic [7:0] body;
      st                     = cobsrx_pkg::STATUS_OK;
      decl                   = declared_ff;
      body                   = 8'd0;
      state_in               = state_ff;
      decoded_count_in       = decoded_count_ff;
      declared_in            = declared_ff;
      crc_in                 = crc_ff;
      rx_crc_in              = rx_crc_ff;
      item_push              = 1'b0;
      new_item.item_kind     = 1'b0;
      new_item.data_byte     = cmd.data;
      new_item.byte_position = decoded_count_ff[7:0];
      new_item.frame_status  = cobsrx_pkg::STATUS_OK;
      new_item.frame_length  = 8'd0;
      new_item.last          = 1'b0;
      if (cmd_pop) begin
         if (cmd.is_close) begin
            if (state_ff == cobsrx_pkg::RX_FRAME) begin
               if (cmd.pre_status != cobsrx_pkg::STATUS_OK) begin
                  st = cmd.pre_status;
               end else if (declared_ff < 8'd2 || decoded_count_ff < {1'b0, declared_ff}) begin
                  st = cobsrx_pkg::STATUS_LEN;
               end else if (rx_crc_ff != crc_ff) begin
                  st = cobsrx_pkg::STATUS_CRC;
               end
               item_push              = 1'b1;
               new_item.item_kind     = 1'b1;
               new_item.data_byte     = 8'd0;
               new_item.byte_position = 8'd0;
               new_item.frame_status  = st;
               new_item.frame_length  = declared_ff;
               new_item.last          = 1'b1;
               state_in = (st == cobsrx_pkg::STATUS_OK) ? cobsrx_pkg::RX_FRAME
                                                        : cobsrx_pkg::RX_HUNT;
            end else begin
               state_in = cobsrx_pkg::RX_FRAME;
            end
            decoded_count_in = 9'd0;
            declared_in      = 8'd0;
            crc_in           = cobsrx_pkg::CrcInit;
            rx_crc_in        = 16'd0;
         end else if (state_ff == cobsrx_pkg::RX_FRAME) begin
            if (decoded_count_ff == 9'd0) begin
               decl = cmd.data;
            end
            declared_in = decl;
            body        = decl - 8'd2;
            if (decl >= 8'd2 && decoded_count_ff < {1'b0, decl}) begin
               if (decoded_count_ff < {1'b0, body}) begin
                  crc_in = cobsrx_pkg::crc_update(crc_ff, cmd.data);
               end else if (decoded_count_ff == {1'b0, body}) begin
                  rx_crc_in = {rx_crc_ff[15:8], cmd.data};
               end else begin
                  rx_crc_in = {cmd.data, rx_crc_ff[7:0]};
               end
            end
            item_push = 1'b1;
            if (decoded_count_ff != 9'h1FF) begin
               decoded_count_in = decoded_count_ff + 9'd1;
            end
         end
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (do_out_pop) begin
         head_in = head_ff + OutPtrW'(1);
      end
      if (item_push && !do_out_pop) begin
         count_in = count_ff + OutCntW'(1);
      end else if (do_out_pop && !item_push) begin
         count_in = count_ff - OutCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= cobsrx_pkg::RX_HUNT;
         decoded_count_ff <= 9'd0;
         declared_ff      <= 8'd0;
         crc_ff           <= cobsrx_pkg::CrcInit;
         rx_crc_ff        <= 16'd0;
         head_ff          <= '0;
         count_ff         <= '0;
      end else begin
         state_ff         <= state_in;
         decoded_count_ff <= decoded_count_in;
         declared_ff      <= declared_in;
         crc_ff           <= crc_in;
         rx_crc_ff        <= rx_crc_in;
         head_ff          <= head_in;
         count_ff         <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_push) begin
         slot_ff[tail] <= new_item;
      end
   end

endmodule

// File: rtl/cobs_crc16_frame_receiver.sv
// cobs frame receiver with crc-16/modbus check, top level
// one byte beat per cycle sustained while req_full is low; a byte's command is registered in the command
// queue and its result in the result queue before the result is on the rsp ports
// the command queue and a two-entry result queue decouple the cobs front from the crc back end;
// req_full rises only when the command queue fills while the result side is stalled
// synchronous reset: hunting for a delimiter, queues empty, crc at 0xffff
module cobs_crc16_frame_receiver #(
   parameter int MAX_RAW_BYTES = cobsrx_pkg::MaxRawBytesDefault,
   parameter int CMD_DEPTH     = cobsrx_pkg::CmdDepthDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_rx_byte,
   output logic       req_full,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic       rsp_item_kind,
   output logic [7:0] rsp_data_byte,
   output logic [7:0] rsp_byte_position,
   output logic [2:0] rsp_frame_status,
   output logic [7:0] rsp_frame_length,
   output logic       rsp_last
);

   logic                 accept;
   logic                 front_valid;
   cobsrx_pkg::cmd_type  front_cmd;
   logic                 q_empty;
   logic                 q_pop;
   cobsrx_pkg::cmd_type  q_cmd;
   cobsrx_pkg::item_type item;

   assign accept = req_push && !req_full;

   cobsrx_front #(
      .MAX_RAW_BYTES(MAX_RAW_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .rx_byte   (req_rx_byte),
      .cmd_valid (front_valid),
      .cmd       (front_cmd)
   );

   cobsrx_queue #(
      .DEPTH(CMD_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_valid),
      .push_cmd (front_cmd),
      .full     (req_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_cmd (q_cmd)
   );

   cobsrx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!q_empty),
      .cmd       (q_cmd),
      .cmd_pop   (q_pop),
      .out_pop   (rsp_pop),
      .out_empty (rsp_empty),
      .out_item  (item)
   );

   assign rsp_item_kind     = item.item_kind;
   assign rsp_data_byte     = item.data_byte;
   assign rsp_byte_position = item.byte_position;
   assign rsp_frame_status  = item.frame_status;
   assign rsp_frame_length  = item.frame_length;
   assign rsp_last          = item.last;

endmodule

// File: sim/cobsrx_frame_checker.sv
// frame checker for the cobs receiver: predicts every result from the accepted byte beats
// and compares each popped result with the oldest prediction, field by field
// depends on cobsrx_pkg
module cobsrx_frame_checker #(
   parameter int MAX_RAW_BYTES = cobsrx_pkg::MaxRawBytesDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_rx_byte,
   input  logic       req_full,
   input  logic       rsp_pop,
   input  logic       rsp_empty,
   input  logic       rsp_item_kind,
   input  logic [7:0] rsp_data_byte,
   input  logic [7:0] rsp_byte_position,
   input  logic [2:0] rsp_frame_status,
   input  logic [7:0] rsp_frame_length,
   input  logic       rsp_last,
   output int         mismatch_count,
   output int         pending_count
);

   bit                     receiving;
   logic [7:0]             block_left;
   logic [7:0]             last_code;
   logic [7:0]             decl_len;
   int                     raw_seen;
   int                     decoded_seen;
   logic [15:0]            calc_crc;
   logic [15:0]            frame_crc;
   cobsrx_pkg::status_type latched_err;
   cobsrx_pkg::item_type   expected_items[$];

   function automatic logic [15:0] modbus_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      repeat (8) c = c[0] ? ({1'b0, c[15:1]} ^ cobsrx_pkg::CrcPoly) : {1'b0, c[15:1]};
      return c;
   endfunction

   function automatic void restart_frame();
      block_left   = 8'h00;
      last_code    = 8'h00;
      raw_seen     = 0;
      decoded_seen = 0;
      decl_len     = 8'h00;
      calc_crc     = cobsrx_pkg::CrcInit;
      frame_crc    = 16'h0000;
      latched_err  = cobsrx_pkg::STATUS_OK;
   endfunction

   function automatic void decode_out(logic [7:0] b);
      cobsrx_pkg::item_type d;
      int                   body;
      if (decoded_seen == 0) decl_len = b;
      if (decl_len >= 2 && decoded_seen < decl_len) begin
         body = decl_len - 2;
         if (decoded_seen < body) calc_crc = modbus_step(calc_crc, b);
         else if (decoded_seen == body) frame_crc[7:0] = b;
         else frame_crc[15:8] = b;
      end
      d.item_kind     = 1'b0;
      d.data_byte     = b;
      d.byte_position = decoded_seen[7:0];
      d.frame_status  = cobsrx_pkg::STATUS_OK;
      d.frame_length  = 8'h00;
      d.last          = 1'b0;
      expected_items.push_back(d);
      if (decoded_seen < 511) decoded_seen++;
   endfunction

   function automatic void predict_byte(logic [7:0] b);
      cobsrx_pkg::item_type   s;
      cobsrx_pkg::status_type st;
      logic                   fill;
      if (!receiving) begin
         if (b == cobsrx_pkg::Delimiter) begin
            restart_frame();
            receiving = 1'b1;
         end
      end else if (b == cobsrx_pkg::Delimiter) begin
         if (latched_err != cobsrx_pkg::STATUS_OK) st = latched_err;
         else if (raw_seen == 0) st = cobsrx_pkg::STATUS_LEN;
         else if (block_left != 8'h00) st = cobsrx_pkg::STATUS_TRUNC;
         else if (decl_len < 2 || decoded_seen < decl_len) st = cobsrx_pkg::STATUS_LEN;
         else if (frame_crc != calc_crc) st = cobsrx_pkg::STATUS_CRC;
         else st = cobsrx_pkg::STATUS_OK;
         s.item_kind     = 1'b1;
         s.data_byte     = 8'h00;
         s.byte_position = 8'h00;
         s.frame_status  = st;
         s.frame_length  = decl_len;
         s.last          = 1'b1;
         expected_items.push_back(s);
         restart_frame();
         receiving = (st == cobsrx_pkg::STATUS_OK);
      end else if (latched_err == cobsrx_pkg::STATUS_OK) begin
         if (raw_seen >= MAX_RAW_BYTES) begin
            latched_err = cobsrx_pkg::STATUS_OVF;
         end else begin
            if (raw_seen < 511) raw_seen++;
            if (block_left == 8'h00) begin
               fill       = (raw_seen > 1) && (last_code != cobsrx_pkg::CodeMax);
               last_code  = b;
               block_left = b - 8'd1;
               if (fill) decode_out(8'h00);
            end else begin
               block_left--;
               decode_out(b);
            end
         end
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      cobsrx_pkg::item_type want;
      if (reset) begin
         receiving = 1'b0;
         restart_frame();
         expected_items.delete();
      end else begin
         if (req_push && !req_full) predict_byte(req_rx_byte);
         if (rsp_pop && !rsp_empty) begin
            if (expected_items.size() == 0) begin
               report_mismatch($sformatf("result beat with nothing expected (kind %0d)",
                                         rsp_item_kind));
            end else begin
               want = expected_items.pop_front();
               if (rsp_item_kind !== want.item_kind)
                  report_mismatch($sformatf("item_kind %0d, expected %0d",
                                            rsp_item_kind, want.item_kind));
               if (rsp_data_byte !== want.data_byte)
                  report_mismatch($sformatf("data_byte %0h, expected %0h",
                                            rsp_data_byte, want.data_byte));
               if (rsp_byte_position !== want.byte_position)
                  report_mismatch($sformatf("byte_position %0d, expected %0d",
                                            rsp_byte_position, want.byte_position));
               if (rsp_frame_status !== want.frame_status)
                  report_mismatch($sformatf("frame_status %0d, expected %0d",
                                            rsp_frame_status, want.frame_status));
               if (rsp_frame_length !== want.frame_length)
                  report_mismatch($sformatf("frame_length %0d, expected %0d",
                                            rsp_frame_length, want.frame_length));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0d, expected %0d", rsp_last, want.last));
            end
         end
      end
      pending_count <= expected_items.size();
   end

endmodule

// File: sim/tb_cobs_crc16_frame_receiver.sv
// testbench top for the cobs frame receiver: sends directed and random cobs frames with
// random gaps on both sides and gives the verdict from the frame checker
// depends on cobsrx_pkg, cobs_crc16_frame_receiver, cobsrx_frame_checker
module tb_cobs_crc16_frame_receiver;

   localparam int RawLimit   = cobsrx_pkg::MaxRawBytesDefault;
   localparam int ByteTarget = 1700;
   localparam int TailCycles = 10;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_push    = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       req_full;
   logic       rsp_pop     = 1'b0;
   logic       rsp_empty;
   logic       rsp_item_kind;
   logic [7:0] rsp_data_byte;
   logic [7:0] rsp_byte_position;
   logic [2:0] rsp_frame_status;
   logic [7:0] rsp_frame_length;
   logic       rsp_last;
   int         mismatches;
   int         pending;

   bit         calm      = 1'b0;
   bit         draining  = 1'b0;
   bit         link_open = 1'b0;
   int         bytes_sent = 0;
   logic [7:0] plain[$];
   logic [7:0] coded[$];

   cobs_crc16_frame_receiver #(
      .MAX_RAW_BYTES(RawLimit)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_rx_byte      (req_rx_byte),
      .req_full         (req_full),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_byte_position(rsp_byte_position),
      .rsp_frame_status (rsp_frame_status),
      .rsp_frame_length (rsp_frame_length),
      .rsp_last         (rsp_last)
   );

   cobsrx_frame_checker #(
      .MAX_RAW_BYTES(RawLimit)
   ) frame_check (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_rx_byte      (req_rx_byte),
      .req_full         (req_full),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_byte_position(rsp_byte_position),
      .rsp_frame_status (rsp_frame_status),
      .rsp_frame_length (rsp_frame_length),
      .rsp_last         (rsp_last),
      .mismatch_count   (mismatches),
      .pending_count    (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #12_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // stretches in which neither side starts a new idle gap
   initial begin
      forever begin
         calm = 1'b0;
         repeat ($urandom_range(150, 500)) @(posedge clock);
         calm = 1'b1;
         repeat ($urandom_range(40, 200)) @(posedge clock);
      end
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (draining) begin
            rsp_pop <= 1'b1;
         end else if (stall > 0) begin
            rsp_pop <= 1'b0;
            stall--;
         end else begin
            rsp_pop <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall = pick_gap();
         end
      end
   end

   function automatic logic [15:0] modbus_crc(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      repeat (8) c = c[0] ? ({1'b0, c[15:1]} ^ cobsrx_pkg::CrcPoly) : {1'b0, c[15:1]};
      return c;
   endfunction

   // decoded frame: length, payload, crc low, crc high, then optional trailing bytes
   function automatic void make_frame(int len, int zero_pct, int extra);
      logic [15:0] crc;
      plain = {};
      plain.push_back(8'(len));
      repeat (len - 3)
         plain.push_back(($urandom_range(0, 99) < zero_pct) ? 8'h00 : 8'($urandom_range(1, 255)));
      crc = cobsrx_pkg::CrcInit;
      foreach (plain[i]) crc = modbus_crc(crc, plain[i]);
      plain.push_back(crc[7:0]);
      plain.push_back(crc[15:8]);
      repeat (extra) plain.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void cobs_pack();
      logic [7:0] run[$];
      coded = {};
      foreach (plain[i]) begin
         if (plain[i] == cobsrx_pkg::Delimiter) begin
            coded.push_back(8'(run.size() + 1));
            foreach (run[j]) coded.push_back(run[j]);
            run = {};
         end else begin
            run.push_back(plain[i]);
            if (run.size() == 254) begin
               coded.push_back(cobsrx_pkg::CodeMax);
               foreach (run[j]) coded.push_back(run[j]);
               run = {};
            end
         end
      end
      coded.push_back(8'(run.size() + 1));
      foreach (run[j]) coded.push_back(run[j]);
   endfunction

   function automatic void fill_noise(int count);
      coded = {};
      repeat (count) coded.push_back(8'($urandom_range(1, 255)));
   endfunction

   // one byte beat per accepted push
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      bytes_sent++;
   endtask

   // sends a coded frame; after an error frame it first reopens the link, at times with junk the hunter must drop
   task automatic send_coded(input bit ok);
      if (!link_open) begin
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(1, 255)));
         send_byte(cobsrx_pkg::Delimiter);
      end
      foreach (coded[i]) send_byte(coded[i]);
      send_byte(cobsrx_pkg::Delimiter);
      link_open = ok;
   endtask

   initial begin
      int kind;
      int len;
      int idx;
      int frame_no;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed frames
      send_byte(8'hFF);
      coded = {};
      send_coded(1'b0);
      make_frame(3, 0, 0);
      cobs_pack();
      send_coded(1'b1);
      make_frame(5, 100, 0);
      cobs_pack();
      send_coded(1'b1);
      make_frame(4, 0, 0);
      plain[3] ^= 8'h01;
      cobs_pack();
      send_coded(1'b0);
      coded = {8'h05, 8'h11, 8'h22};
      send_coded(1'b0);
      coded = {8'h02, 8'h01};
      send_coded(1'b0);

      // random frames
      frame_no = 0;
      while (bytes_sent < ByteTarget) begin
         kind = $urandom_range(0, 99);
         if (frame_no == 3 || frame_no == 7) kind = 99;
         idx = $urandom_range(0, 99);
         if (idx < 80) len = $urandom_range(3, 24);
         else if (idx < 97) len = $urandom_range(25, 120);
         else len = $urandom_range(121, 239);
         case ($urandom_range(0, 3))
            0: idx = 0;
            1: idx = 5;
            2: idx = 30;
            default: idx = 70;
         endcase
         if (kind >= 98) begin
            len = $urandom_range(240, 255);
            idx = 0;
         end
         make_frame(len, idx, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0);
         if (kind >= 60 && kind < 70) begin
            idx = $urandom_range(1, len - 1);
            plain[idx] ^= 8'(1 << $urandom_range(0, 7));
         end else if (kind >= 70 && kind < 78) begin
            if (len < 255 && $urandom_range(0, 1) == 1) plain[0] = 8'($urandom_range(len + 1, 255));
            else plain[0] = 8'($urandom_range(0, 2));
         end
         cobs_pack();
         if (kind >= 78 && kind < 86) begin
            repeat ($urandom_range(1, 3)) if (coded.size() > 1) void'(coded.pop_back());
         end else if (kind >= 86 && kind < 92) begin
            fill_noise($urandom_range(1, 20));
         end else if (kind >= 92 && kind < 95) begin
            coded = {};
         end else if (kind == 99 && $urandom_range(0, 1) == 1) begin
            fill_noise($urandom_range(RawLimit + 1, RawLimit + 24));
         end
         send_coded(kind < 60);
         frame_no++;
      end

      req_push <= 1'b0;
      draining = 1'b1;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      if (mismatches == 0 && pending == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
